// File: hw/rtl/vmis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmis_pkg
// Shared codes and types for the Vole machine instruction step block.
// ----------------------------------------------------------------------------
package vmis_pkg;

	localparam int MEM_DEPTH = 256;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int RF_DEPTH  = 16;
	localparam int RF_AW     = $clog2(RF_DEPTH);

	localparam logic [2:0] ACT_WRITE   = 3'd0;
	localparam logic [2:0] ACT_STEP    = 3'd1;
	localparam logic [2:0] ACT_RESTART = 3'd2;
	localparam logic [2:0] ACT_READM   = 3'd3;
	localparam logic [2:0] ACT_READR   = 3'd4;
	localparam logic [2:0] ACT_CLEAR   = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_HALT    = 2'd2;
	localparam logic [1:0] ST_HALTED  = 2'd3;

	localparam logic [3:0] OP_LOAD  = 4'h1;
	localparam logic [3:0] OP_LDI   = 4'h2;
	localparam logic [3:0] OP_STORE = 4'h3;
	localparam logic [3:0] OP_MOVE  = 4'h4;
	localparam logic [3:0] OP_ADD   = 4'h5;
	localparam logic [3:0] OP_NOP   = 4'h6;
	localparam logic [3:0] OP_JUMP  = 4'hB;
	localparam logic [3:0] OP_HALT  = 4'hC;

	typedef struct packed {
		logic              rf_we;
		logic [RF_AW-1:0]  rf_waddr;
		logic [7:0]        rf_wdata;
		logic              mem_we;
		logic [MEM_AW-1:0] mem_waddr;
		logic [7:0]        mem_wdata;
		logic [7:0]        pc_next;
		logic              halt;
		logic [1:0]        status;
		logic [3:0]        opcode;
		logic              out_valid;
		logic [7:0]        out_value;
	} exec_t;

endpackage

// File: hw/rtl/vole_machine_instruction_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vole_machine_instruction_step
// 8-bit teaching machine: memory and register commands, one-instruction step.
//
//  channel  | signals                                       | handshake
//  ---------+-----------------------------------------------+----------------
//  request  | action, address, data, reg_select             | start & !busy
//  result   | status, pc, opcode, read_data, out_valid/value| done, 1 cycle
//  config   | psel, penable, pwrite, paddr, pwdata, prdata  | pready high
//
//  Write, restart, clear, halted step, unused actions: result in the next
//  cycle, busy stays low. Read memory/register: via S_RD. Step: S_FETCH1,
//  S_FETCH2, S_EXEC (two fetches and an operand read on the single memory read port, then execute).
//  Reset and clear-all zero memory and registers at once via valid bits.
//  The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module vole_machine_instruction_step (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] action,
	input  logic [7:0] address,
	input  logic [7:0] data,
	input  logic [3:0] reg_select,
	output logic       done,
	output logic [1:0] status,
	output logic [7:0] pc,
	output logic [3:0] opcode,
	output logic [7:0] read_data,
	output logic       out_valid,
	output logic [7:0] out_value,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	import vmis_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_RD     = 5'b00010,
		S_FETCH1 = 5'b00100,
		S_FETCH2 = 5'b01000,
		S_EXEC   = 5'b10000
	} state_t;

	state_t state_q;

	logic [7:0]          mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] mem_vld_q;
	logic [7:0]          rf_q [RF_DEPTH];
	logic [RF_DEPTH-1:0] rf_vld_q;

	logic [7:0]        mem_rd_q, rf_a_q, rf_b_q;
	logic [MEM_AW-1:0] mem_raddr, mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_we, rf_we, clr;
	logic [RF_AW-1:0]  rf_ra, rf_rb;

	logic [7:0] pc_q, start_q, hi_q, lo_q;
	logic       halted_q, is_reg_q, done_q;
	logic [1:0] status_q;
	logic [3:0] opcode_q;
	logic [7:0] rdata_q, ovalue_q;
	logic       ovalid_q;

	logic       accept;
	exec_t      ex;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign clr    = accept && action == ACT_CLEAR;

	vmis_exec u_exec (
		.hi      (hi_q),
		.lo      (lo_q),
		.mem_val (mem_rd_q),
		.rf_a    (rf_a_q),
		.rf_b    (rf_b_q),
		.pc      (pc_q),
		.ex      (ex)
	);

	// read address select
	always_comb begin
		mem_raddr = pc_q;
		rf_ra     = reg_select;
		rf_rb     = '0;
		unique case (state_q)
			S_IDLE:   mem_raddr = (action == ACT_READM) ? address : pc_q;
			S_FETCH1: mem_raddr = pc_q + 8'd1;
			S_FETCH2: begin
				mem_raddr = mem_rd_q;
				case (hi_q[7:4]) inside
					OP_MOVE, OP_ADD: rf_ra = mem_rd_q[7:4];
					default:         rf_ra = hi_q[3:0];
				endcase
				if (hi_q[7:4] == OP_ADD)
					rf_rb = mem_rd_q[3:0];
			end
			S_RD, S_EXEC: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = address;
		mem_wdata = data;
		if (accept && action == ACT_WRITE) begin
			mem_we = 1'b1;
		end else if (state_q == S_EXEC && ex.mem_we) begin
			mem_we    = 1'b1;
			mem_waddr = ex.mem_waddr;
			mem_wdata = ex.mem_wdata;
		end
	end

	assign rf_we = (state_q == S_EXEC) && ex.rf_we;

	// main memory and register file
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		mem_rd_q <= mem_vld_q[mem_raddr] ? mem_q[mem_raddr] : 8'd0;
		if (rf_we)
			rf_q[ex.rf_waddr] <= ex.rf_wdata;
		rf_a_q <= rf_vld_q[rf_ra] ? rf_q[rf_ra] : 8'd0;
		rf_b_q <= rf_vld_q[rf_rb] ? rf_q[rf_rb] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= '0;
			rf_vld_q  <= '0;
		end else if (clr) begin
			mem_vld_q <= '0;
			rf_vld_q  <= '0;
		end else begin
			if (mem_we)
				mem_vld_q[mem_waddr] <= 1'b1;
			if (rf_we)
				rf_vld_q[ex.rf_waddr] <= 1'b1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			pc_q     <= '0;
			halted_q <= 1'b0;
			start_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (psel && penable && pwrite && !paddr[2])
				start_q <= pwdata[7:0];
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_STEP: begin
								if (halted_q)
									done_q <= 1'b1;
								else
									state_q <= S_FETCH1;
							end
							ACT_RESTART: begin
								pc_q     <= start_q;
								halted_q <= 1'b0;
								done_q   <= 1'b1;
							end
							ACT_CLEAR: begin
								pc_q     <= '0;
								halted_q <= 1'b0;
								done_q   <= 1'b1;
							end
							ACT_READM, ACT_READR: state_q <= S_RD;
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_RD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FETCH1: state_q <= S_FETCH2;
				S_FETCH2: state_q <= S_EXEC;
				S_EXEC: begin
					pc_q     <= ex.pc_next;
					halted_q <= halted_q | ex.halt;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result and instruction holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			is_reg_q <= (action == ACT_READR);
			status_q <= (action == ACT_STEP && halted_q) ? ST_HALTED : ST_OK;
			opcode_q <= '0;
			rdata_q  <= '0;
			ovalid_q <= 1'b0;
			ovalue_q <= '0;
		end
		if (state_q == S_FETCH1)
			hi_q <= mem_rd_q;
		if (state_q == S_FETCH2)
			lo_q <= mem_rd_q;
		if (state_q == S_RD)
			rdata_q <= is_reg_q ? rf_a_q : mem_rd_q;
		if (state_q == S_EXEC) begin
			status_q <= ex.status;
			opcode_q <= ex.opcode;
			ovalid_q <= ex.out_valid;
			ovalue_q <= ex.out_value;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign pc        = pc_q;
	assign opcode    = opcode_q;
	assign read_data = rdata_q;
	assign out_valid = ovalid_q;
	assign out_value = ovalue_q;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {24'd0, start_q};

endmodule

// File: hw/rtl/vmis_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmis_exec
// Instruction execute: decodes the fetched word and forms all write-backs.
// ----------------------------------------------------------------------------
module vmis_exec (
	input  logic [7:0]     hi,
	input  logic [7:0]     lo,
	input  logic [7:0]     mem_val,
	input  logic [7:0]     rf_a,
	input  logic [7:0]     rf_b,
	input  logic [7:0]     pc,
	output vmis_pkg::exec_t ex
);
	import vmis_pkg::*;

	logic [3:0] op;
	logic [3:0] r;

	assign op = hi[7:4];
	assign r  = hi[3:0];

	always_comb begin
		ex           = '0;
		ex.opcode    = op;
		ex.pc_next   = pc + 8'd2;
		ex.rf_waddr  = r;
		ex.mem_waddr = lo;
		ex.mem_wdata = rf_a;
		ex.status    = ST_OK;
		unique case (op)
			OP_LOAD: begin
				ex.rf_we    = 1'b1;
				ex.rf_wdata = mem_val;
			end
			OP_LDI: begin
				ex.rf_we    = 1'b1;
				ex.rf_wdata = lo;
			end
			OP_STORE: begin
				ex.mem_we = 1'b1;
				if (lo == 8'd0) begin
					ex.out_valid = 1'b1;
					ex.out_value = rf_a;
				end
			end
			OP_MOVE: begin
				ex.rf_we    = 1'b1;
				ex.rf_waddr = lo[3:0];
				ex.rf_wdata = rf_a;
			end
			OP_ADD: begin
				ex.rf_we    = 1'b1;
				ex.rf_wdata = rf_a + rf_b;
			end
			OP_NOP: begin
			end
			OP_JUMP: begin
				if (rf_a == rf_b)
					ex.pc_next = lo;
			end
			OP_HALT: begin
				if (r == 4'd0 && lo == 8'd0) begin
					ex.halt   = 1'b1;
					ex.status = ST_HALT;
				end else begin
					ex.status = ST_INVALID;
				end
			end
			default: ex.status = ST_INVALID;
		endcase
	end

endmodule

// File: tb/sv/tb_vole_machine_instruction_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vole_machine_instruction_step
// Self-checking bench for the Vole machine instruction step block.
//
// Requests go in on the start/busy handshake. A shadow copy of memory,
// registers, pc and halt flag predicts every result, and results are
// checked in order as done pulses. Directed cases cover field extremes,
// fetch wrap, halt, invalid codes, unused actions and clear. Random phases
// under several start addresses then load short programs, restart, step
// them, and mix in reads and noise requests.
// ----------------------------------------------------------------------------
module tb_vole_machine_instruction_step;

	import vmis_pkg::*;

	localparam logic [2:0] CFG_START_ADDR = 3'd0;
	localparam logic [2:0] ACT_UNUSED_6   = 3'd6;
	localparam logic [2:0] ACT_UNUSED_7   = 3'd7;
	localparam int         WATCHDOG_LIMIT = 400;
	localparam int         PHASE_ITEMS    = 110;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] address;
		logic [7:0] data;
		logic [3:0] reg_select;
	} vole_request_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] pc;
		logic [3:0] opcode;
		logic [7:0] read_data;
		logic       out_valid;
		logic [7:0] out_value;
	} vole_result_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [2:0]  action     = '0;
	logic [7:0]  address    = '0;
	logic [7:0]  data       = '0;
	logic [3:0]  reg_select = '0;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = '0;
	logic [31:0] pwdata     = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [7:0]  pc;
	logic [3:0]  opcode;
	logic [7:0]  read_data;
	logic        out_valid;
	logic [7:0]  out_value;
	logic [31:0] prdata;
	logic        pready;

	// shadow machine state
	logic [7:0] mem_img [0:MEM_DEPTH-1];
	logic [7:0] regs_img [0:RF_DEPTH-1];
	logic [7:0] pc_img;
	logic       halted_img;
	logic [7:0] start_addr_img;

	vole_result_t expected_results[$];
	int           mismatches     = 0;
	int           accepted_items = 0;
	int           idle_cycles    = 0;
	bit           back_to_back   = 1'b0;

	vole_machine_instruction_step uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .address(address), .data(data), .reg_select(reg_select),
		.done(done), .status(status), .pc(pc), .opcode(opcode),
		.read_data(read_data), .out_valid(out_valid), .out_value(out_value),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	function automatic vole_result_t vole_execute(input vole_request_t rq);
		vole_result_t r;
		logic [7:0]   hi;
		logic [7:0]   lo;
		logic [7:0]   pc_next;
		logic [3:0]   rn;
		r = '0;
		case (rq.action)
			ACT_WRITE: mem_img[rq.address] = rq.data;
			ACT_READM: r.read_data = mem_img[rq.address];
			ACT_READR: r.read_data = regs_img[rq.reg_select];
			ACT_RESTART: begin
				pc_img = start_addr_img;
				halted_img = 1'b0;
			end
			ACT_CLEAR: begin
				for (int i = 0; i < MEM_DEPTH; i++) mem_img[i] = '0;
				for (int i = 0; i < RF_DEPTH; i++) regs_img[i] = '0;
				pc_img = '0;
				halted_img = 1'b0;
			end
			ACT_STEP: begin
				if (halted_img) begin
					r.status = ST_HALTED;
				end else begin
					pc_next = pc_img + 8'd1;
					hi = mem_img[pc_img];
					lo = mem_img[pc_next];
					rn = hi[3:0];
					pc_img = pc_img + 8'd2;
					r.opcode = hi[7:4];
					case (hi[7:4])
						OP_LOAD: regs_img[rn] = mem_img[lo];
						OP_LDI: regs_img[rn] = lo;
						OP_STORE: begin
							mem_img[lo] = regs_img[rn];
							if (lo == 8'd0) begin
								r.out_valid = 1'b1;
								r.out_value = regs_img[rn];
							end
						end
						OP_MOVE: regs_img[lo[3:0]] = regs_img[lo[7:4]];
						OP_ADD: regs_img[rn] = regs_img[lo[7:4]] + regs_img[lo[3:0]];
						OP_NOP: ;
						OP_JUMP: begin
							if (regs_img[rn] == regs_img[0]) pc_img = lo;
						end
						OP_HALT: begin
							if (rn == 4'd0 && lo == 8'd0) begin
								halted_img = 1'b1;
								r.status = ST_HALT;
							end else begin
								r.status = ST_INVALID;
							end
						end
						default: r.status = ST_INVALID;
					endcase
				end
			end
			default: ;
		endcase
		r.pc = pc_img;
		return r;
	endfunction

	function automatic logic [15:0] random_instruction(input logic [7:0] base, input int n);
		logic [3:0] op;
		logic [3:0] rn;
		logic [7:0] lo;
		rn = 4'($urandom_range(0, 15));
		lo = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 19))
			0, 1: op = OP_LOAD;
			2, 3, 4: op = OP_LDI;
			5, 6: begin
				op = OP_STORE;
				if ($urandom_range(0, 2) == 0) lo = '0;
			end
			7, 8: op = OP_MOVE;
			9, 10, 11: op = OP_ADD;
			12: op = OP_NOP;
			13, 14: begin
				op = OP_JUMP;
				if ($urandom_range(0, 3) != 0)
					lo = base + 8'(2 * $urandom_range(0, n - 1));
			end
			15: begin
				op = OP_HALT;
				rn = '0;
				lo = '0;
			end
			16: op = OP_HALT;
			default: op = 4'($urandom_range(0, 15));
		endcase
		return {op, rn, lo};
	endfunction

	task automatic send_request(input logic [2:0] act, input logic [7:0] addr,
			input logic [7:0] dat, input logic [3:0] rsel);
		int            gap;
		vole_request_t rq;
		vole_result_t  prediction;
		gap = back_to_back ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		action     <= act;
		address    <= addr;
		data       <= dat;
		reg_select <= rsel;
		do @(posedge clk); while (busy);
		rq = '{act, addr, dat, rsel};
		prediction = vole_execute(rq);
		expected_results = {expected_results, prediction};
		accepted_items++;
	endtask

	task automatic send_random_fields(input logic [2:0] act);
		send_request(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			4'($urandom_range(0, 15)));
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_start_address(input logic [7:0] value);
		logic [31:0] readback;
		wait_all_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_START_ADDR;
		pwdata  <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		start_addr_img = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback[7:0] !== value) begin
			mismatches++;
			if (mismatches <= 10)
				$display("start_address readback: expected %02h actual %02h", value, readback[7:0]);
		end
	endtask

	task automatic test_memory_extremes();
		send_request(ACT_WRITE, 8'hFF, 8'hFF, 4'hF);
		send_request(ACT_READM, 8'hFF, 8'h00, 4'h0);
		send_request(ACT_READR, 8'h00, 8'hFF, 4'hF);
	endtask

	// program at FE..07: fetch wraps, store to 00 drives the port, add wraps,
	// C with nonzero low bits is invalid, then halt and a step while halted
	task automatic test_program_wrap();
		write_start_address(8'hFE);
		send_request(ACT_WRITE, 8'hFE, {OP_LDI, 4'h1}, 4'h0);
		send_request(ACT_WRITE, 8'hFF, 8'hFF, 4'h0);
		send_request(ACT_WRITE, 8'h00, {OP_STORE, 4'h1}, 4'h0);
		send_request(ACT_WRITE, 8'h01, 8'h00, 4'h0);
		send_request(ACT_WRITE, 8'h02, {OP_ADD, 4'h1}, 4'h0);
		send_request(ACT_WRITE, 8'h03, 8'h11, 4'h0);
		send_request(ACT_WRITE, 8'h04, {OP_HALT, 4'h0}, 4'h0);
		send_request(ACT_WRITE, 8'h05, 8'h01, 4'h0);
		send_request(ACT_WRITE, 8'h06, {OP_HALT, 4'h0}, 4'h0);
		send_request(ACT_WRITE, 8'h07, 8'h00, 4'h0);
		send_request(ACT_RESTART, 8'h00, 8'h00, 4'h0);
		repeat (6) send_random_fields(ACT_STEP);
		send_request(ACT_READR, 8'h00, 8'h00, 4'h1);
	endtask

	task automatic test_unused_and_clear();
		send_request(ACT_UNUSED_6, 8'hFF, 8'hFF, 4'hF);
		send_request(ACT_UNUSED_7, 8'h00, 8'h00, 4'h0);
		send_request(ACT_CLEAR, 8'h55, 8'hAA, 4'h5);
		send_request(ACT_READM, 8'hFF, 8'h00, 4'h0);
	endtask

	task automatic run_program();
		int          n;
		logic [7:0]  base;
		logic [7:0]  a;
		logic [15:0] ins;
		n = $urandom_range(2, 8);
		base = start_addr_img;
		if ($urandom_range(0, 5) == 0)
			send_random_fields(ACT_CLEAR);
		for (int i = 0; i < n; i++) begin
			if (i == n - 1 && $urandom_range(0, 3) != 0) ins = {OP_HALT, 12'h000};
			else ins = random_instruction(base, n);
			a = base + 8'(2 * i);
			send_request(ACT_WRITE, a, ins[15:8], 4'($urandom_range(0, 15)));
			send_request(ACT_WRITE, a + 8'd1, ins[7:0], 4'($urandom_range(0, 15)));
		end
		send_random_fields(ACT_RESTART);
		for (int i = 0; i < n + 2; i++) begin
			send_random_fields(ACT_STEP);
			case ($urandom_range(0, 7))
				0: send_random_fields(ACT_READR);
				1: send_random_fields(ACT_READM);
				2: send_random_fields(3'($urandom_range(0, 7)));
				default: ;
			endcase
		end
	endtask

	task automatic test_random_programs();
		logic [7:0] settings [0:5];
		int         phase_start;
		settings[0] = 8'h00;
		settings[1] = 8'hFF;
		settings[2] = 8'($urandom_range(0, 255));
		settings[3] = 8'($urandom_range(0, 255));
		settings[4] = 8'($urandom_range(0, 255));
		settings[5] = 8'h00;
		for (int p = 0; p < 6; p++) begin
			write_start_address(settings[p]);
			phase_start = accepted_items;
			while (accepted_items - phase_start < PHASE_ITEMS) begin
				back_to_back = ($urandom_range(0, 3) == 0);
				run_program();
			end
			back_to_back = 1'b0;
		end
	endtask

	always @(posedge clk) begin : result_check
		vole_result_t got;
		vole_result_t want;
		if (arst_n && done) begin
			got = '{status, pc, opcode, read_data, out_valid, out_value};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status=%0d pc=%02h", got.status, got.pc);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.pc !== want.pc ||
						got.opcode !== want.opcode || got.read_data !== want.read_data ||
						got.out_valid !== want.out_valid || got.out_value !== want.out_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: expected st=%0d pc=%02h op=%h rd=%02h ov=%0d ",
							"oval=%02h, actual st=%0d pc=%02h op=%h rd=%02h ov=%0d oval=%02h"},
							want.status, want.pc, want.opcode, want.read_data,
							want.out_valid, want.out_value, got.status, got.pc, got.opcode,
							got.read_data, got.out_valid, got.out_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("vole_machine_instruction_step test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < MEM_DEPTH; i++) mem_img[i] = '0;
		for (int i = 0; i < RF_DEPTH; i++) regs_img[i] = '0;
		pc_img = '0;
		halted_img = 1'b0;
		start_addr_img = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_memory_extremes();
		test_program_wrap();
		test_unused_and_clear();
		test_random_programs();
		wait_all_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("vole_machine_instruction_step test passed");
		else
			$display("vole_machine_instruction_step test failed");
		$finish;
	end

endmodule
